>>> rtl/dmpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpm_pkg
// Shared types and constants of the multi-pattern DNA matcher.
// ----------------------------------------------------------------------------
package dmpm_pkg;

    localparam int STATE_W      = 12;
    localparam int STATE_COUNT  = 1 << STATE_W;
    localparam int LETTER_W     = 2;
    localparam int TRANS_AW     = STATE_W + LETTER_W;
    localparam int TRANS_DEPTH  = 1 << TRANS_AW;
    localparam int SYMBOL_W     = 8;
    localparam int MASK_W       = 64;
    localparam int MARKER_COUNT = 64;

    localparam logic [STATE_W-1:0] START_INDEX = STATE_W'(1);
    localparam logic [MASK_W-1:0]  MARKER_LIMIT = {MASK_W{1'b1}} >> (MASK_W - MARKER_COUNT);

    localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
    localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;
    localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;
    localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
    localparam logic [SYMBOL_W-1:0] CHAR_N = 8'h4E;

    localparam logic [LETTER_W-1:0] COL_A = 2'd0;
    localparam logic [LETTER_W-1:0] COL_T = 2'd1;
    localparam logic [LETTER_W-1:0] COL_G = 2'd2;
    localparam logic [LETTER_W-1:0] COL_C = 2'd3;

    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_TRANS = 2'd1,
        ACT_MASK  = 2'd2
    } action_t;

    // Access requests from the stream control to the table storage.
    typedef struct packed {
        logic                trans_we;
        logic [TRANS_AW-1:0] trans_waddr;
        logic [STATE_W-1:0]  trans_wdata;
        logic                trans_re;
        logic [TRANS_AW-1:0] trans_raddr;
        logic                mask_we;
        logic [STATE_W-1:0]  mask_waddr;
        logic [MASK_W-1:0]   mask_wdata;
        logic                mask_re;
        logic [STATE_W-1:0]  mask_raddr;
    } tbl_req_t;

endpackage

>>> rtl/dmpm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpm_stream_if
// Input channel: sequence characters and table load words.
// ----------------------------------------------------------------------------
interface dmpm_stream_if;
    import dmpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [SYMBOL_W-1:0] symbol;
    logic                last_symbol;
    logic [STATE_W-1:0]  entry_state;
    logic [LETTER_W-1:0] entry_letter;
    logic [STATE_W-1:0]  entry_next;
    logic [MASK_W-1:0]   entry_mask;

    modport source (
        output valid, action, symbol, last_symbol, entry_state, entry_letter,
               entry_next, entry_mask,
        input  ready
    );

    modport sink (
        input  valid, action, symbol, last_symbol, entry_state, entry_letter,
               entry_next, entry_mask,
        output ready
    );
endinterface

>>> rtl/dmpm_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpm_result_if
// Result channel: found marker mask and bad character flag per sequence.
// ----------------------------------------------------------------------------
interface dmpm_result_if;
    import dmpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] found_mask;
    logic              bad_symbol_seen;

    modport source (
        output valid, found_mask, bad_symbol_seen,
        input  ready
    );

    modport sink (
        input  valid, found_mask, bad_symbol_seen,
        output ready
    );
endinterface

>>> rtl/dna_multi_pattern_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_multi_pattern_matcher_core
// Aho-Corasick matcher over DNA character streams with host-loaded tables.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle, whether a sequence character or a
// table load word. It keeps that rate while at most one result waits at the
// output. Once both output slots are taken, the input stalls until the
// receiver takes a result. A character passes the input register, the
// transition table read (whose registered read data is itself the automaton
// state, so the state loop closes through that one read), the marker mask
// read, and the accumulation of the found mask. Both tables come up
// undefined and must be loaded by the host before any sequence uses the
// entries; there is no clearing pass after reset. N returns the automaton to
// the start state; any other byte outside A, T, G and C does the same and
// sets the bad flag.

module dna_multi_pattern_matcher_core
    import dmpm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dmpm_stream_if.sink   stream,
    dmpm_result_if.source result
);

    typedef struct packed {
        logic                letter;
        logic                bad;
        logic [LETTER_W-1:0] col;
    } sym_class_t;

    function automatic sym_class_t classify(input logic [SYMBOL_W-1:0] sym);
        sym_class_t c;
        c = '{letter: 1'b1, bad: 1'b0, col: COL_A};
        case (sym)
            CHAR_A:  c.col = COL_A;
            CHAR_T:  c.col = COL_T;
            CHAR_G:  c.col = COL_G;
            CHAR_C:  c.col = COL_C;
            CHAR_N:  c.letter = 1'b0;
            default:
            begin
                c.letter = 1'b0;
                c.bad    = 1'b1;
            end
        endcase
        return c;
    endfunction

    // Stage 1: registered input word.
    logic                s1_valid_reg;
    logic [1:0]          s1_action_reg;
    logic [SYMBOL_W-1:0] s1_symbol_reg;
    logic                s1_last_reg;
    logic [STATE_W-1:0]  s1_state_reg;
    logic [LETTER_W-1:0] s1_letter_reg;
    logic [STATE_W-1:0]  s1_next_reg;
    logic [MASK_W-1:0]   s1_mask_reg;

    // Stages 2 and 3: characters only.
    logic s2_valid_reg, s2_letter_reg, s2_bad_reg, s2_last_reg;
    logic s3_valid_reg, s3_letter_reg, s3_bad_reg, s3_last_reg;

    logic              use_start_reg;
    logic [MASK_W-1:0] seen_reg, seen_next;
    logic              bad_reg, bad_next;

    logic              out_valid_reg, skid_valid_reg;
    logic [MASK_W-1:0] out_mask_reg, skid_mask_reg;
    logic              out_bad_reg, skid_bad_reg;

    logic               adv;
    logic               pop;
    logic               push;
    logic               s1_char;
    sym_class_t         s1_class;
    logic [STATE_W-1:0] lookup_state;
    logic [STATE_W-1:0] trans_rdata;
    logic [MASK_W-1:0]  mask_rdata;
    tbl_req_t           tbl_req;

    // The pipeline moves as a whole; it halts only when both output slots
    // are occupied, so no ready-to-ready path exists.
    assign adv          = !(out_valid_reg && skid_valid_reg);
    assign stream.ready = adv;
    assign pop          = out_valid_reg && result.ready;
    assign push         = adv && s3_valid_reg && s3_last_reg;

    assign s1_class     = classify(s1_symbol_reg);
    assign lookup_state = use_start_reg ? START_INDEX : trans_rdata;

    always_comb
    begin
        s1_char = 1'b0;
        tbl_req = '0;
        tbl_req.trans_waddr = {s1_state_reg, s1_letter_reg};
        tbl_req.trans_wdata = s1_next_reg;
        tbl_req.trans_raddr = {lookup_state, s1_class.col};
        tbl_req.mask_waddr  = s1_state_reg;
        tbl_req.mask_wdata  = s1_mask_reg;
        tbl_req.mask_raddr  = trans_rdata;
        tbl_req.mask_re     = adv && s2_valid_reg && s2_letter_reg;
        if (adv && s1_valid_reg)
        begin
            unique case (s1_action_reg)
                ACT_CHAR:
                begin
                    s1_char          = 1'b1;
                    tbl_req.trans_re = s1_class.letter;
                end
                ACT_TRANS: tbl_req.trans_we = 1'b1;
                ACT_MASK:  tbl_req.mask_we  = 1'b1;
                default:   s1_char = 1'b0;
            endcase
        end
    end

    dmpm_tables u_tables (
        .clk         (clk),
        .req         (tbl_req),
        .trans_rdata (trans_rdata),
        .mask_rdata  (mask_rdata)
    );

    always_comb
    begin
        seen_next = seen_reg | (s3_letter_reg ? mask_rdata : '0);
        bad_next  = bad_reg | s3_bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            use_start_reg <= 1'b1;
            seen_reg      <= '0;
            bad_reg       <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= stream.valid;
            s2_valid_reg <= s1_char;
            s3_valid_reg <= s2_valid_reg;
            if (s1_char)
            begin
                use_start_reg <= !s1_class.letter || s1_last_reg;
            end
            if (s3_valid_reg)
            begin
                if (s3_last_reg)
                begin
                    seen_reg <= '0;
                    bad_reg  <= 1'b0;
                end
                else
                begin
                    seen_reg <= seen_next;
                    bad_reg  <= bad_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_action_reg <= stream.action;
            s1_symbol_reg <= stream.symbol;
            s1_last_reg   <= stream.last_symbol;
            s1_state_reg  <= stream.entry_state;
            s1_letter_reg <= stream.entry_letter;
            s1_next_reg   <= stream.entry_next;
            s1_mask_reg   <= stream.entry_mask;
            s2_letter_reg <= s1_class.letter;
            s2_bad_reg    <= s1_class.bad;
            s2_last_reg   <= s1_last_reg;
            s3_letter_reg <= s2_letter_reg;
            s3_bad_reg    <= s2_bad_reg;
            s3_last_reg   <= s2_last_reg;
        end
    end

    // Two-slot output: the result register and a skid slot behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop && skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= push;
        end
        else if (pop || !out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_mask_reg  <= skid_mask_reg;
            out_bad_reg   <= skid_bad_reg;
            skid_mask_reg <= seen_next & MARKER_LIMIT;
            skid_bad_reg  <= bad_next;
        end
        else if (pop || !out_valid_reg)
        begin
            out_mask_reg <= seen_next & MARKER_LIMIT;
            out_bad_reg  <= bad_next;
        end
        else if (push)
        begin
            skid_mask_reg <= seen_next & MARKER_LIMIT;
            skid_bad_reg  <= bad_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.found_mask      = out_mask_reg;
    assign result.bad_symbol_seen = out_bad_reg;

endmodule

>>> rtl/dmpm_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpm_tables
// Transition table and marker mask table, each with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module dmpm_tables
    import dmpm_pkg::*;
(
    input  logic               clk,
    input  tbl_req_t           req,
    output logic [STATE_W-1:0] trans_rdata,
    output logic [MASK_W-1:0]  mask_rdata
);

    logic [STATE_W-1:0] trans_mem [TRANS_DEPTH];
    logic [MASK_W-1:0]  mask_mem  [STATE_COUNT];
    logic [STATE_W-1:0] trans_rdata_reg;
    logic [MASK_W-1:0]  mask_rdata_reg;

    // The read registers hold their value when no read is requested; the
    // transition read register doubles as the automaton state.
    always_ff @(posedge clk)
    begin
        if (req.trans_we)
        begin
            trans_mem[req.trans_waddr] <= req.trans_wdata;
        end
        if (req.trans_re)
        begin
            trans_rdata_reg <= trans_mem[req.trans_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.mask_we)
        begin
            mask_mem[req.mask_waddr] <= req.mask_wdata;
        end
        if (req.mask_re)
        begin
            mask_rdata_reg <= mask_mem[req.mask_raddr];
        end
    end

    assign trans_rdata = trans_rdata_reg;
    assign mask_rdata  = mask_rdata_reg;

endmodule
